[sv/gapsm_pkg.sv]
// Shared types, register indexes and Gray-coded coefficient tables for the
// ASK/PSK symbol mapper. No dependencies.
package gapsm_pkg;

    // Longest run of repeated samples for one symbol
    localparam int MAX_REPEAT = 64;
    localparam int REP_W      = $clog2(MAX_REPEAT + 1);

    // Configuration port widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int AMP_W      = 15;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int FRAC_W     = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODULATION_MODE    = 2'd0,
        REG_BITS_PER_SYMBOL    = 2'd1,
        REG_SAMPLES_PER_SYMBOL = 2'd2,
        REG_AMPLITUDE          = 2'd3
    } t_reg_idx;

    typedef enum logic {
        MODE_ASK = 1'b0,
        MODE_PSK = 1'b1
    } t_mode;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        t_coef p;
        t_coef q;
    } t_coef_pair;

    // Q2.14 coefficients
    localparam t_coef Q_ONE   = 16'sd16384;
    localparam t_coef Q_R2    = 16'sd11585;
    localparam t_coef Q_ZERO  = 16'sd0;
    localparam t_coef Q_1_3   = 16'sd5461;
    localparam t_coef Q_2_3   = 16'sd10923;
    localparam t_coef Q_1_7   = 16'sd2341;
    localparam t_coef Q_2_7   = 16'sd4681;
    localparam t_coef Q_3_7   = 16'sd7022;
    localparam t_coef Q_4_7   = 16'sd9362;
    localparam t_coef Q_5_7   = 16'sd11703;
    localparam t_coef Q_6_7   = 16'sd14043;

    // Look up the I/Q coefficients of a symbol; bps is already 1..3
    function automatic t_coef_pair coef_lookup(input logic mode, input logic [1:0] bps,
                                               input logic [2:0] sym);
        t_coef_pair c;
        c.p = Q_ZERO;
        c.q = Q_ZERO;
        if (mode == MODE_ASK) begin
            case (bps)
                2'd1: c.p = sym[0] ? Q_ONE : Q_ZERO;
                2'd2: begin
                    case (sym[1:0])
                        2'd0:    c.p = Q_ZERO;
                        2'd1:    c.p = Q_1_3;
                        2'd2:    c.p = Q_ONE;
                        default: c.p = Q_2_3;
                    endcase
                end
                default: begin
                    case (sym)
                        3'd0:    c.p = Q_ZERO;
                        3'd1:    c.p = Q_1_7;
                        3'd2:    c.p = Q_3_7;
                        3'd3:    c.p = Q_2_7;
                        3'd4:    c.p = Q_ONE;
                        3'd5:    c.p = Q_6_7;
                        3'd6:    c.p = Q_4_7;
                        default: c.p = Q_5_7;
                    endcase
                end
            endcase
        end else begin
            case (bps)
                2'd1: c.p = sym[0] ? -Q_ONE : Q_ONE;
                2'd2: begin
                    c.p = sym[1] ? -Q_R2 : Q_R2;
                    c.q = sym[0] ? -Q_R2 : Q_R2;
                end
                default: begin
                    case (sym)
                        3'd0:    begin c.p = Q_ONE;  c.q = Q_ZERO; end
                        3'd1:    begin c.p = Q_R2;   c.q = Q_R2;   end
                        3'd2:    begin c.p = -Q_R2;  c.q = Q_R2;   end
                        3'd3:    begin c.p = Q_ZERO; c.q = Q_ONE;  end
                        3'd4:    begin c.p = Q_R2;   c.q = -Q_R2;  end
                        3'd5:    begin c.p = Q_ZERO; c.q = -Q_ONE; end
                        3'd6:    begin c.p = -Q_ONE; c.q = Q_ZERO; end
                        default: begin c.p = -Q_R2;  c.q = -Q_R2;  end
                    endcase
                end
            endcase
        end
        return c;
    endfunction

endpackage

[sv/gray_ask_psk_symbol_mapper.sv]
// Gray-coded ASK/PSK baseband symbol mapper, top level.
// Depends on gapsm_pkg for register indexes, widths and coefficient tables.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one data bit per beat, most
//   significant bit of each symbol first. Bits are gathered until
//   bits_per_symbol of them form a symbol; beats that do not complete a
//   symbol produce nothing. The completed symbol is looked up, scaled by the
//   amplitude register and sent on the output channel (o_valid / i_ready) as
//   samples_per_symbol identical I/Q beats, the last one with o_symbol_end.
//   Pipeline: the coefficient register loads at the edge that accepts the
//   completing beat, and the product register loads from it once the
//   output register is free.
//   Throughput: one data bit per cycle while o_ready is high; a symbol holds
//   the output register for samples_per_symbol beats (1..64), so the input
//   accepts bits while the coefficient slot is free and stalls only when a
//   second finished symbol waits behind one still draining.
//   Receiver stall: the output beat holds, the coefficient slot fills and
//   then o_ready drops; nothing is lost.
//   Reset (synchronous, i_rst_n low): registers return to ASK, one bit per
//   symbol, one sample per symbol, amplitude 16384; partial symbol and both
//   pipeline slots are emptied.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx at once;
//   write only while the block is idle.
module gray_ask_psk_symbol_mapper
    import gapsm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write port
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    // input bit channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_data_bit,
    // output sample channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_in_phase,
    output logic signed [SAMPLE_W-1:0] o_quadrature,
    output logic                       o_symbol_end
);

    // configuration registers
    logic               r_mode;
    logic [1:0]         r_bps;
    logic [6:0]         r_sps;
    logic [AMP_W-1:0]   r_amp;

    // symbol gathering state
    logic [2:0]         r_partial;
    logic [1:0]         r_gathered;

    // coefficient slot
    logic               r_sym_vld;
    t_coef_pair         r_coef;

    // output register
    logic               r_out_vld;
    logic [REP_W-1:0]   r_rem;
    logic signed [SAMPLE_W-1:0] r_i;
    logic signed [SAMPLE_W-1:0] r_q;

    logic               in_take;
    logic               out_take;
    logic               out_last;
    logic               load_out;
    logic [1:0]         bps_eff;
    logic [REP_W-1:0]   reps_eff;
    logic [2:0]         n_partial;
    logic [1:0]         n_gathered;
    logic               sym_done;
    logic [2:0]         sym_mask;
    t_coef_pair         n_coef;
    logic signed [COEF_W+AMP_W:0] prod_i;
    logic signed [COEF_W+AMP_W:0] prod_q;

    // Clamp the configured symbol size and repeat count
    assign bps_eff  = (r_bps == 2'd0) ? 2'd1 : r_bps;
    always_comb begin
        if (r_sps == 7'd0) begin
            reps_eff = REP_W'(1);
        end else if (REP_W'(r_sps) > REP_W'(MAX_REPEAT)) begin
            reps_eff = REP_W'(MAX_REPEAT);
        end else begin
            reps_eff = REP_W'(r_sps);
        end
    end

    // Handshakes
    assign out_last = (r_rem == REP_W'(1));
    assign out_take = r_out_vld && i_ready;
    assign load_out = r_sym_vld && (!r_out_vld || (out_take && out_last));
    assign o_ready  = !r_sym_vld || load_out;
    assign in_take  = i_valid && o_ready;

    // Shift in the new bit and decide whether the symbol is complete
    assign n_partial  = {r_partial[1:0], i_data_bit};
    assign n_gathered = r_gathered + 2'd1;
    assign sym_done   = !((n_gathered < bps_eff) && (n_gathered != 2'd0));
    always_comb begin
        case (bps_eff)
            2'd1:    sym_mask = 3'b001;
            2'd2:    sym_mask = 3'b011;
            default: sym_mask = 3'b111;
        endcase
    end
    assign n_coef = coef_lookup(r_mode, bps_eff, n_partial & sym_mask);

    // Scale both coefficients by the amplitude; floor shift by 14
    assign prod_i = $signed({1'b0, r_amp}) * r_coef.p;
    assign prod_q = $signed({1'b0, r_amp}) * r_coef.q;

    // Hold configuration, gathering state and both pipeline slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_bps      <= 2'd1;
            r_sps      <= 7'd1;
            r_amp      <= AMP_W'(16384);
            r_partial  <= 3'd0;
            r_gathered <= 2'd0;
            r_sym_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
            r_rem      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_MODULATION_MODE:    r_mode <= i_cfg_data[0];
                    REG_BITS_PER_SYMBOL:    r_bps  <= i_cfg_data[1:0];
                    REG_SAMPLES_PER_SYMBOL: r_sps  <= i_cfg_data[6:0];
                    REG_AMPLITUDE:          r_amp  <= i_cfg_data[AMP_W-1:0];
                    default: ;
                endcase
            end

            // advance gathering; a finished symbol fills the coefficient slot
            if (in_take) begin
                if (sym_done) begin
                    r_partial  <= 3'd0;
                    r_gathered <= 2'd0;
                end else begin
                    r_partial  <= n_partial;
                    r_gathered <= n_gathered;
                end
            end
            if (in_take && sym_done) begin
                r_sym_vld <= 1'b1;
            end else if (load_out) begin
                r_sym_vld <= 1'b0;
            end

            // output register: load a symbol or count down its repeats
            if (load_out) begin
                r_out_vld <= 1'b1;
                r_rem     <= reps_eff;
            end else if (out_take) begin
                if (out_last) begin
                    r_out_vld <= 1'b0;
                end
                r_rem <= r_rem - REP_W'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take && sym_done) begin
            r_coef <= n_coef;
        end
        if (load_out) begin
            r_i <= prod_i[FRAC_W+SAMPLE_W-1:FRAC_W];
            r_q <= prod_q[FRAC_W+SAMPLE_W-1:FRAC_W];
        end
    end

    assign o_valid      = r_out_vld;
    assign o_in_phase   = r_i;
    assign o_quadrature = r_q;
    assign o_symbol_end = r_out_vld && out_last;

    // A live output beat always has between one and MAX_REPEAT repeats left
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_rem != '0) && (r_rem <= REP_W'(MAX_REPEAT)))
        else $error("repeat count out of range");

    // The input stalls only behind a waiting symbol
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_sym_vld && r_out_vld)
        else $error("input stalled with a free slot");

    // A non-final sample taken leaves the same symbol with one repeat fewer
    a_repeat_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && !out_last |=> r_out_vld && (r_rem == $past(r_rem) - REP_W'(1)))
        else $error("repeat countdown slipped");

    // A symbol loaded into the output frees the coefficient slot unless a new symbol refills it
    a_slot_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out && !(in_take && sym_done) |=> !r_sym_vld && r_out_vld)
        else $error("coefficient slot not released");

endmodule
